>>> sv/gcns_pkg.sv
package gcns_pkg;

	localparam int NEEDLE_W  = 20;
	localparam int READING_W = 16;
	localparam int CFG_W     = 8;

	typedef logic [NEEDLE_W-1:0] needle_t;
	typedef logic signed [READING_W-1:0] reading_t;
	typedef logic [CFG_W-1:0] cfg_data_t;

	typedef enum logic {
		OP_SET  = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		GAUGE_RPM   = 2'd0,
		GAUGE_SPEED = 2'd1,
		GAUGE_FUEL  = 2'd2,
		GAUGE_TEMP  = 2'd3
	} gauge_t;

	typedef enum logic [1:0] {
		REG_FUEL_LOW_ON   = 2'd0,
		REG_FUEL_LOW_OFF  = 2'd1,
		REG_OVERHEAT_ON   = 2'd2,
		REG_OVERHEAT_OFF  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		op_t      op;
		gauge_t   gauge;
		reading_t reading;
	} item_t;

	// scaling
	localparam int MUL_A_W = 15;
	localparam int MUL_B_W = 19;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	localparam logic [MUL_B_W-1:0] RPM_GAIN   = 19'd7123;
	localparam logic [MUL_B_W-1:0] SPEED_GAIN = 19'd355522;
	localparam logic [MUL_B_W-1:0] FUEL_GAIN  = 19'd10485;
	localparam logic [MUL_B_W-1:0] TEMP_GAIN  = 19'd8738;

	localparam int RPM_OFFSET    = 250;
	localparam int SPEED_DEAD    = 5;
	localparam int SPEED_OFFSET  = 75;
	localparam int FUEL_MAX_IN   = 100;
	localparam int TEMP_MIN_IN   = 35;
	localparam int TEMP_MAX_IN   = 155;
	localparam int SHIFT_WIDE    = 14;
	localparam int SHIFT_NARROW  = 10;
	localparam needle_t FULL_SCALE = 20'd1024;

	// slew
	localparam int BAND_FUEL   = 15;
	localparam int BAND_OTHER  = 30;
	localparam int STEP_FUEL   = 10;
	localparam int STEP_SMALL  = 21;
	localparam int STEP_LARGE  = 42;
	localparam int NEAR_LIMIT  = 128;

	localparam cfg_data_t FUEL_LOW_ON_RST  = 8'd10;
	localparam cfg_data_t FUEL_LOW_OFF_RST = 8'd13;
	localparam cfg_data_t OVERHEAT_ON_RST  = 8'd110;
	localparam cfg_data_t OVERHEAT_OFF_RST = 8'd95;

endpackage

>>> sv/gcns_in_if.sv
interface gcns_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [1:0]  gauge;
	logic [15:0] reading;

	modport source (output valid, output op, output gauge, output reading, input ready);
	modport sink (input valid, input op, input gauge, input reading, output ready);
endinterface

>>> sv/gcns_out_if.sv
interface gcns_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  which_gauge;
	logic [19:0] needle;
	logic        settled;
	logic        warning_on;
	logic        warning_changed;

	modport source (output valid, output which_gauge, output needle, output settled,
		output warning_on, output warning_changed, input ready);
	modport sink (input valid, input which_gauge, input needle, input settled,
		input warning_on, input warning_changed, output ready);
endinterface

>>> sv/gcns_cfg_if.sv
interface gcns_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/gcns_scale.sv
module gcns_scale (
	input  gcns_pkg::gauge_t   gauge,
	input  gcns_pkg::reading_t reading,
	output gcns_pkg::needle_t  target
);
	import gcns_pkg::*;

	logic signed [READING_W:0] rs;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic [NEEDLE_W:0]  spd;

	assign rs = {reading[READING_W-1], reading};

	// one shared constant multiplier, operand picked per gauge
	always_comb begin
		case (gauge)
			GAUGE_RPM: begin
				mul_a = (rs > RPM_OFFSET) ? MUL_A_W'(rs - RPM_OFFSET) : '0;
				mul_b = RPM_GAIN;
			end
			GAUGE_SPEED: begin
				mul_a = (rs > SPEED_DEAD) ? reading[MUL_A_W-1:0] : '0;
				mul_b = SPEED_GAIN;
			end
			GAUGE_FUEL: begin
				mul_a = MUL_A_W'(reading[6:0]);
				mul_b = FUEL_GAIN;
			end
			default: begin
				mul_a = MUL_A_W'(rs - TEMP_MIN_IN);
				mul_b = TEMP_GAIN;
			end
		endcase
	end

	assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
	assign spd  = (NEEDLE_W+1)'(prod >> SHIFT_WIDE);

	always_comb begin
		case (gauge)
			GAUGE_RPM: target = NEEDLE_W'(prod >> SHIFT_WIDE);
			GAUGE_SPEED: target = (spd < SPEED_OFFSET) ? '0 : NEEDLE_W'(spd - SPEED_OFFSET);
			GAUGE_FUEL: begin
				if (rs < 0)
					target = '0;
				else if (rs > FUEL_MAX_IN)
					target = FULL_SCALE;
				else
					target = NEEDLE_W'(prod >> SHIFT_NARROW);
			end
			default: begin
				if (rs < TEMP_MIN_IN)
					target = '0;
				else if (rs > TEMP_MAX_IN)
					target = FULL_SCALE;
				else
					target = NEEDLE_W'(prod >> SHIFT_NARROW);
			end
		endcase
	end
endmodule

>>> sv/gauge_cluster_needle_slew.sv
// A tick result is held in the input register, then the result register; a set gives none.
// Throughput: one item per cycle while no tick waits on a stalled output; the input
// register and result register let a new item in while a finished result waits on the output.
// Reset (arst_n, asynchronous): targets and positions zero, low fuel flag set,
// overheat clear, first warning report pending, thresholds at 10, 13, 110 and 95.
module gauge_cluster_needle_slew (
	input  logic clk,
	input  logic arst_n,
	gcns_in_if.sink    in_ch,
	gcns_out_if.source out_ch,
	gcns_cfg_if.sink   cfg
);
	import gcns_pkg::*;

	cfg_data_t fuel_low_on_q, fuel_low_off_q, overheat_on_q, overheat_off_q;
	needle_t   targets_q   [4];
	needle_t   positions_q [4];
	logic      low_fuel_q, overheat_q;
	logic [1:0] shown_q, pending_q;

	item_t item_s1;
	logic  valid_s1;

	logic       out_valid_s2;
	gauge_t     gauge_s2;
	needle_t    needle_s2;
	logic       settled_s2, won_s2, wchg_s2;

	logic advance;
	logic is_tick;
	needle_t new_target;

	logic signed [READING_W:0]  rs;
	logic signed [NEEDLE_W:0]   diff;
	logic [NEEDLE_W:0]          abs_diff;
	logic [5:0]                 step;
	logic                       snap;
	logic signed [NEEDLE_W+1:0] moved;
	needle_t                    new_pos;
	logic                       widx;
	logic                       won, wchg;

	assign cfg.ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fuel_low_on_q  <= FUEL_LOW_ON_RST;
			fuel_low_off_q <= FUEL_LOW_OFF_RST;
			overheat_on_q  <= OVERHEAT_ON_RST;
			overheat_off_q <= OVERHEAT_OFF_RST;
		end else if (cfg.valid) begin
			unique case (reg_idx_t'(cfg.index))
				REG_FUEL_LOW_ON:  fuel_low_on_q  <= cfg.data;
				REG_FUEL_LOW_OFF: fuel_low_off_q <= cfg.data;
				REG_OVERHEAT_ON:  overheat_on_q  <= cfg.data;
				REG_OVERHEAT_OFF: overheat_off_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign is_tick    = (item_s1.op == OP_TICK);
	assign advance    = valid_s1 && (!is_tick || !out_valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1 <= '{op: op_t'(in_ch.op), gauge: gauge_t'(in_ch.gauge),
				reading: reading_t'(in_ch.reading)};
		end
	end

	gcns_scale u_scale (
		.gauge   (item_s1.gauge),
		.reading (item_s1.reading),
		.target  (new_target)
	);

	assign rs = {item_s1.reading[READING_W-1], item_s1.reading};

	// slew step
	always_comb begin
		diff = $signed({1'b0, targets_q[item_s1.gauge]})
			- $signed({1'b0, positions_q[item_s1.gauge]});
		abs_diff = diff[NEEDLE_W] ? (NEEDLE_W+1)'(-diff) : (NEEDLE_W+1)'(diff);
		if (item_s1.gauge == GAUGE_FUEL)
			snap = abs_diff < BAND_FUEL;
		else
			snap = abs_diff < BAND_OTHER;
		case (item_s1.gauge)
			GAUGE_FUEL: step = 6'(STEP_FUEL);
			GAUGE_TEMP: step = 6'(STEP_SMALL);
			default:    step = (abs_diff < NEAR_LIMIT) ? 6'(STEP_SMALL) : 6'(STEP_LARGE);
		endcase
		if (diff > 0)
			moved = $signed({2'b00, positions_q[item_s1.gauge]}) + $signed({16'd0, step});
		else
			moved = $signed({2'b00, positions_q[item_s1.gauge]}) - $signed({16'd0, step});
		if (snap)
			new_pos = targets_q[item_s1.gauge];
		else if (moved < 0)
			new_pos = '0;
		else if (moved[NEEDLE_W+1:NEEDLE_W] != 2'b00)
			new_pos = '1;
		else
			new_pos = moved[NEEDLE_W-1:0];
	end

	// warning report
	always_comb begin
		widx = item_s1.gauge[0];
		won  = 1'b0;
		wchg = 1'b0;
		if (item_s1.gauge == GAUGE_FUEL || item_s1.gauge == GAUGE_TEMP) begin
			won  = (item_s1.gauge == GAUGE_FUEL) ? low_fuel_q : overheat_q;
			wchg = pending_q[widx] || (shown_q[widx] != won);
		end
	end

	// gauge state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				targets_q[i]   <= '0;
				positions_q[i] <= '0;
			end
			low_fuel_q <= 1'b1;
			overheat_q <= 1'b0;
			shown_q    <= '0;
			pending_q  <= '1;
		end else if (advance) begin
			if (!is_tick) begin
				targets_q[item_s1.gauge] <= new_target;
				if (item_s1.gauge == GAUGE_FUEL) begin
					if (rs < $signed({9'd0, fuel_low_on_q}) && !low_fuel_q)
						low_fuel_q <= 1'b1;
					else if (rs > $signed({9'd0, fuel_low_off_q}) && low_fuel_q)
						low_fuel_q <= 1'b0;
				end else if (item_s1.gauge == GAUGE_TEMP) begin
					if (rs > $signed({9'd0, overheat_on_q}) && !overheat_q)
						overheat_q <= 1'b1;
					else if (rs < $signed({9'd0, overheat_off_q}) && overheat_q)
						overheat_q <= 1'b0;
				end
			end else begin
				positions_q[item_s1.gauge] <= new_pos;
				if (item_s1.gauge == GAUGE_FUEL || item_s1.gauge == GAUGE_TEMP) begin
					pending_q[widx] <= 1'b0;
					shown_q[widx]   <= won;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance && is_tick) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_tick) begin
			gauge_s2   <= item_s1.gauge;
			needle_s2  <= new_pos;
			settled_s2 <= snap;
			won_s2     <= won;
			wchg_s2    <= wchg;
		end
	end

	assign out_ch.valid           = out_valid_s2;
	assign out_ch.which_gauge     = gauge_s2;
	assign out_ch.needle          = needle_s2;
	assign out_ch.settled         = settled_s2;
	assign out_ch.warning_on      = won_s2;
	assign out_ch.warning_changed = wchg_s2;
endmodule

>>> sim/gauge_needle_checker.sv
module gauge_needle_checker (
	input  logic clk,
	input  logic arst_n,
	gcns_in_if   in_ch,
	gcns_out_if  out_ch,
	gcns_cfg_if  cfg,
	output int   faults,
	output int   awaiting
);
	import gcns_pkg::*;

	localparam int NEEDLE_MAX = (1 << NEEDLE_W) - 1;

	typedef struct packed {
		gauge_t  gauge;
		needle_t needle;
		logic    settled;
		logic    warning_on;
		logic    warning_changed;
	} tick_report_t;

	tick_report_t tick_reports[$];

	int   thr_low_on;
	int   thr_low_off;
	int   thr_hot_on;
	int   thr_hot_off;
	int   target_of[4];
	int   position_of[4];
	logic low_fuel;
	logic overheat;
	logic shown[2];
	logic first_due[2];

	function automatic int scale_reading(gauge_t g, int r);
		longint t;
		case (g)
			GAUGE_RPM: begin
				if (r <= RPM_OFFSET)
					return 0;
				return int'((longint'(r - RPM_OFFSET) * longint'(RPM_GAIN)) >>> SHIFT_WIDE);
			end
			GAUGE_SPEED: begin
				if (r <= SPEED_DEAD)
					r = 0;
				t = ((longint'(r) * longint'(SPEED_GAIN)) >>> SHIFT_WIDE) - SPEED_OFFSET;
				return (t < 0) ? 0 : int'(t);
			end
			GAUGE_FUEL: begin
				if (r < 0)
					return 0;
				if (r > FUEL_MAX_IN)
					return int'(FULL_SCALE);
				return int'((longint'(r) * longint'(FUEL_GAIN)) >>> SHIFT_NARROW);
			end
			default: begin
				if (r < TEMP_MIN_IN)
					return 0;
				if (r > TEMP_MAX_IN)
					return int'(FULL_SCALE);
				return int'((longint'(r - TEMP_MIN_IN) * longint'(TEMP_GAIN)) >>> SHIFT_NARROW);
			end
		endcase
	endfunction

	function automatic void apply_reading(gauge_t g, int r);
		target_of[g] = scale_reading(g, r) & NEEDLE_MAX;
		if (g == GAUGE_FUEL) begin
			if (r < thr_low_on && !low_fuel)
				low_fuel = 1'b1;
			else if (r > thr_low_off && low_fuel)
				low_fuel = 1'b0;
		end else if (g == GAUGE_TEMP) begin
			if (r > thr_hot_on && !overheat)
				overheat = 1'b1;
			else if (r < thr_hot_off && overheat)
				overheat = 1'b0;
		end
	endfunction

	function automatic tick_report_t slew_needle(gauge_t g);
		tick_report_t rep;
		int pos;
		int diff;
		int band;
		int step;
		int w;
		pos = position_of[g];
		diff = target_of[g] - pos;
		band = (g == GAUGE_FUEL) ? BAND_FUEL : BAND_OTHER;
		rep.gauge = g;
		rep.warning_on = 1'b0;
		rep.warning_changed = 1'b0;
		if (diff > -band && diff < band) begin
			pos = target_of[g];
			rep.settled = 1'b1;
		end else begin
			if (g == GAUGE_FUEL)
				step = STEP_FUEL;
			else if (g == GAUGE_TEMP)
				step = STEP_SMALL;
			else
				step = (diff > -NEAR_LIMIT && diff < NEAR_LIMIT) ? STEP_SMALL : STEP_LARGE;
			pos = (diff > 0) ? pos + step : pos - step;
			if (pos < 0)
				pos = 0;
			if (pos > NEEDLE_MAX)
				pos = NEEDLE_MAX;
			rep.settled = 1'b0;
		end
		position_of[g] = pos;
		rep.needle = needle_t'(pos);
		if (g == GAUGE_FUEL || g == GAUGE_TEMP) begin
			w = (g == GAUGE_FUEL) ? 0 : 1;
			rep.warning_on = (g == GAUGE_FUEL) ? low_fuel : overheat;
			rep.warning_changed = first_due[w] || (shown[w] != rep.warning_on);
			first_due[w] = 1'b0;
			shown[w] = rep.warning_on;
		end
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_report_t want;
		tick_report_t got;
		if (!arst_n) begin
			thr_low_on = int'(FUEL_LOW_ON_RST);
			thr_low_off = int'(FUEL_LOW_OFF_RST);
			thr_hot_on = int'(OVERHEAT_ON_RST);
			thr_hot_off = int'(OVERHEAT_OFF_RST);
			for (int i = 0; i < 4; i++) begin
				target_of[i] = 0;
				position_of[i] = 0;
			end
			low_fuel = 1'b1;
			overheat = 1'b0;
			shown[0] = 1'b0;
			shown[1] = 1'b0;
			first_due[0] = 1'b1;
			first_due[1] = 1'b1;
			tick_reports.delete();
			faults = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_FUEL_LOW_ON:  thr_low_on = int'(cfg.data);
					REG_FUEL_LOW_OFF: thr_low_off = int'(cfg.data);
					REG_OVERHEAT_ON:  thr_hot_on = int'(cfg.data);
					REG_OVERHEAT_OFF: thr_hot_off = int'(cfg.data);
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				if (op_t'(in_ch.op) == OP_TICK)
					tick_reports.push_back(slew_needle(gauge_t'(in_ch.gauge)));
				else
					apply_reading(gauge_t'(in_ch.gauge), int'(reading_t'(in_ch.reading)));
			end
			if (out_ch.valid && out_ch.ready) begin
				got.gauge = gauge_t'(out_ch.which_gauge);
				got.needle = out_ch.needle;
				got.settled = out_ch.settled;
				got.warning_on = out_ch.warning_on;
				got.warning_changed = out_ch.warning_changed;
				if (tick_reports.size() == 0) begin
					if (faults < 10)
						$display("unexpected tick result: gauge %0d needle %0d",
							got.gauge, got.needle);
					faults++;
				end else begin
					want = tick_reports.pop_front();
					if (got !== want) begin
						if (faults < 10)
							$display("expected %0d %0d %0b %0b %0b got %0d %0d %0b %0b %0b",
								want.gauge, want.needle, want.settled, want.warning_on,
								want.warning_changed, got.gauge, got.needle, got.settled,
								got.warning_on, got.warning_changed);
						faults++;
					end
				end
			end
		end
		awaiting = tick_reports.size();
	end

endmodule

>>> sim/gauge_cluster_needle_slew_tb.sv
module gauge_cluster_needle_slew_tb;
	import gcns_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int SEGMENT_ITEMS = 145;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   faults;
	int   awaiting;
	int   cycles = 0;
	int   in_idle_pct = 22;
	int   out_idle_pct = 78;

	gcns_in_if  in_ch();
	gcns_out_if out_ch();
	gcns_cfg_if cfg();

	gauge_cluster_needle_slew dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	gauge_needle_checker needle_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg      (cfg),
		.faults   (faults),
		.awaiting (awaiting)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(input op_t op, input gauge_t g, input int r);
		while ($urandom_range(99) < in_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.gauge <= g;
		in_ch.reading <= r[15:0];
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input cfg_data_t val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every tick result, then let in-flight sets finish
	task automatic drain_results(input int tail);
		in_ch.valid <= 1'b0;
		do
			@(negedge clk);
		while (awaiting != 0);
		repeat (tail)
			@(posedge clk);
	endtask

	function automatic int pick_reading(gauge_t g);
		int sel;
		sel = $urandom_range(99);
		if (sel < 15)
			return int'($urandom);
		if (sel < 25)
			return -int'($urandom_range(40));
		case (g)
			GAUGE_RPM:   return int'($urandom_range(1500));
			GAUGE_SPEED: return int'($urandom_range(60));
			GAUGE_FUEL: begin
				if (sel < 60)
					return int'($urandom_range(20));
				if (sel < 80)
					return int'($urandom_range(255));
				return int'($urandom_range(130)) - 10;
			end
			default: begin
				if (sel < 60)
					return int'($urandom_range(130, 80));
				if (sel < 80)
					return int'($urandom_range(255));
				return int'($urandom_range(190)) - 10;
			end
		endcase
	endfunction

	initial begin
		int sent;
		int ticks;
		gauge_t g;
		in_ch.valid = 1'b0;
		in_ch.op = OP_SET;
		in_ch.gauge = GAUGE_RPM;
		in_ch.reading = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_FUEL_LOW_ON;
		cfg.data = '0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// first reports, extremes and scaling edges
		send_item(OP_TICK, GAUGE_FUEL, 0);
		send_item(OP_TICK, GAUGE_TEMP, -1);
		send_item(OP_TICK, GAUGE_RPM, 32767);
		send_item(OP_SET, GAUGE_RPM, 32767);
		send_item(OP_TICK, GAUGE_RPM, 0);
		send_item(OP_TICK, GAUGE_RPM, 0);
		send_item(OP_SET, GAUGE_RPM, 250);
		send_item(OP_TICK, GAUGE_RPM, -32768);
		send_item(OP_SET, GAUGE_RPM, 251);
		send_item(OP_SET, GAUGE_SPEED, 5);
		send_item(OP_SET, GAUGE_SPEED, 6);
		send_item(OP_TICK, GAUGE_SPEED, 0);
		send_item(OP_SET, GAUGE_SPEED, 32767);
		send_item(OP_TICK, GAUGE_SPEED, 0);
		send_item(OP_SET, GAUGE_SPEED, -32768);
		send_item(OP_TICK, GAUGE_SPEED, 0);
		send_item(OP_SET, GAUGE_FUEL, -32768);
		send_item(OP_SET, GAUGE_FUEL, 101);
		send_item(OP_TICK, GAUGE_FUEL, 0);
		send_item(OP_SET, GAUGE_FUEL, 100);
		send_item(OP_SET, GAUGE_FUEL, 9);
		send_item(OP_TICK, GAUGE_FUEL, 0);
		send_item(OP_SET, GAUGE_TEMP, 156);
		send_item(OP_TICK, GAUGE_TEMP, 0);
		send_item(OP_SET, GAUGE_TEMP, 34);
		send_item(OP_TICK, GAUGE_TEMP, 0);
		send_item(OP_SET, GAUGE_TEMP, 32767);

		for (int seg = 0; seg < 6; seg++) begin
			drain_results(4);
			case (seg)
				0: begin
					write_reg(REG_FUEL_LOW_ON, cfg_data_t'($urandom_range(255)));
					write_reg(REG_FUEL_LOW_OFF, cfg_data_t'($urandom_range(255)));
					write_reg(REG_OVERHEAT_ON, cfg_data_t'($urandom_range(255)));
					write_reg(REG_OVERHEAT_OFF, cfg_data_t'($urandom_range(255)));
				end
				1: begin
					write_reg(REG_FUEL_LOW_ON, 8'd0);
					write_reg(REG_FUEL_LOW_OFF, 8'd0);
					write_reg(REG_OVERHEAT_ON, 8'd0);
					write_reg(REG_OVERHEAT_OFF, 8'd0);
				end
				2: begin
					write_reg(REG_FUEL_LOW_ON, 8'd255);
					write_reg(REG_FUEL_LOW_OFF, 8'd255);
					write_reg(REG_OVERHEAT_ON, 8'd255);
					write_reg(REG_OVERHEAT_OFF, 8'd255);
				end
				3: begin
					write_reg(REG_FUEL_LOW_ON, 8'd255);
					write_reg(REG_FUEL_LOW_OFF, 8'd0);
					write_reg(REG_OVERHEAT_ON, 8'd0);
					write_reg(REG_OVERHEAT_OFF, 8'd255);
				end
				4: begin
					write_reg(REG_FUEL_LOW_ON, cfg_data_t'($urandom_range(15, 5)));
					write_reg(REG_FUEL_LOW_OFF, cfg_data_t'($urandom_range(25, 10)));
					write_reg(REG_OVERHEAT_ON, cfg_data_t'($urandom_range(120, 100)));
					write_reg(REG_OVERHEAT_OFF, cfg_data_t'($urandom_range(105, 85)));
				end
				default: begin
					write_reg(REG_FUEL_LOW_ON, 8'd0);
					write_reg(REG_FUEL_LOW_OFF, 8'd255);
					write_reg(REG_OVERHEAT_ON, 8'd255);
					write_reg(REG_OVERHEAT_OFF, 8'd0);
				end
			endcase
			if (seg < 2) begin
				in_idle_pct = 22;
				out_idle_pct = 78;
			end else if (seg < 4) begin
				in_idle_pct = 78;
				out_idle_pct = 22;
			end else begin
				in_idle_pct = 0;
				out_idle_pct = 0;
			end
			sent = 0;
			while (sent < SEGMENT_ITEMS) begin
				g = gauge_t'($urandom_range(3));
				if ($urandom_range(99) < 70) begin
					// new target, then slew towards it
					send_item(OP_SET, g, pick_reading(g));
					ticks = $urandom_range(8, 1);
					for (int k = 0; k < ticks; k++)
						send_item(OP_TICK, g, int'($urandom));
					sent += ticks + 1;
				end else begin
					if ($urandom_range(1))
						send_item(OP_TICK, g, int'($urandom));
					else
						send_item(OP_SET, g, pick_reading(g));
					sent++;
				end
			end
		end

		drain_results(8);
		if (faults == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/gcns_pkg.sv
sv/gcns_in_if.sv
sv/gcns_out_if.sv
sv/gcns_cfg_if.sv
sv/gcns_scale.sv
sv/gauge_cluster_needle_slew.sv
sim/gauge_needle_checker.sv
sim/gauge_cluster_needle_slew_tb.sv
